// ===== rtl/fcd_pkg.sv =====
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types, constants and elaboration helpers for the feedback comb delay.
// ----------------------------------------------------------------------------
package fcd_pkg;

	localparam int RING_DEPTH_DEF = 4096;
	localparam int DLY_W          = 13;
	localparam int SMP_W          = 16;
	localparam int DLY_RST        = 4096;

	typedef enum logic [0:0] {
		REG_DELAY_LENGTH  = 1'b0,
		REG_FEEDBACK_GAIN = 1'b1
	} reg_idx_t;

	// largest k with depth << k still a valid delay code, -1 if none
	function automatic int max_shift(input int depth);
		int k;
		k = -1;
		for (int i = 0; i < 16; i++) begin
			if ((longint'(depth) << i) <= longint'((1 << DLY_W) - 1))
				k = i;
		end
		return k;
	endfunction

endpackage

// ===== rtl/feedback_comb_delay_top.sv =====
// ----------------------------------------------------------------------------
// feedback_comb_delay_top
// Feedback comb filter on a ring of RING_DEPTH Q1.15 samples held in one
// synchronous RAM: out = in + gain * ring[write - delay], saturated.
// ----------------------------------------------------------------------------
// One transaction per clock cycle is accepted while no delay reduction runs
// and the output is not stalled. Each sample makes one RAM read when accepted
// and one write of its result when it moves on to the output register; a
// result needed by the very next sample is forwarded from the write register.
// The RAM is not cleared: a fill flag and the write index mark slots not yet
// written, which read as zero. After a write of delay_length the delay is
// reduced modulo RING_DEPTH by shifted subtraction, one step per cycle, and
// sample input is held off while it runs, one step for each shift from
// max_shift(RING_DEPTH) down to 0 (none when RING_DEPTH exceeds 8191).
module feedback_comb_delay_top #(
	parameter int RING_DEPTH = fcd_pkg::RING_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [0:0]                         cfg_index,
	input  logic [fcd_pkg::SMP_W-1:0]          cfg_data,
	input  logic                               smp_valid,
	output logic                               smp_ready,
	input  logic signed [fcd_pkg::SMP_W-1:0]   sample_in,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic signed [fcd_pkg::SMP_W-1:0]   sample_out
);

	localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int DLW   = fcd_pkg::DLY_W;
	localparam int SW    = fcd_pkg::SMP_W;
	localparam int MAXK  = fcd_pkg::max_shift(RING_DEPTH);
	localparam int STEPK = (MAXK < 0) ? 0 : MAXK;

	logic [SW-1:0]        mem [RING_DEPTH];

	logic [DLW-1:0]       dly_q;
	logic signed [SW-1:0] gain_q;
	logic                 busy_q;
	logic [3:0]           step_q;
	logic [DLW:0]         step_val;

	logic [AW-1:0]        wi_q;
	logic                 wrap_q;
	logic [AW:0]          wi_x;
	logic [AW:0]          d_x;
	logic [AW-1:0]        rd_c;
	logic                 accept;
	logic                 adv;

	logic                 v_s1;
	logic [AW-1:0]        wi_s1;
	logic                 fwd_s1;
	logic                 zero_s1;
	logic signed [SW-1:0] sample_s1;
	logic [SW-1:0]        rdata_s1;
	logic [SW-1:0]        last_q;

	logic signed [SW-1:0] dval_c;
	logic signed [31:0]   prod_c;
	logic signed [31:0]   biased_c;
	logic signed [16:0]   rnd_c;
	logic signed [17:0]   sum_c;
	logic signed [SW-1:0] sat_c;

	logic                 out_v_q;

	assign adv       = v_s1 && (!out_v_q || res_ready);
	assign smp_ready = !busy_q && (!v_s1 || adv);
	assign accept    = smp_valid && smp_ready;
	assign res_valid = out_v_q;

	// read address: (write index - delay) modulo depth
	always_comb begin
		wi_x = {1'b0, wi_q};
		d_x  = (AW+1)'(dly_q);
		if (wi_x >= d_x)
			rd_c = AW'(wi_x - d_x);
		else
			rd_c = AW'(wi_x + (AW+1)'(RING_DEPTH) - d_x);
	end

	assign step_val = (DLW+1)'(RING_DEPTH) << step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_q  <= DLW'(fcd_pkg::DLY_RST % RING_DEPTH);
			gain_q <= '0;
			busy_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (fcd_pkg::reg_idx_t'(cfg_index))
					fcd_pkg::REG_DELAY_LENGTH: begin
						dly_q  <= cfg_data[DLW-1:0];
						busy_q <= (MAXK >= 0);
						step_q <= 4'(STEPK);
					end
					fcd_pkg::REG_FEEDBACK_GAIN: begin
						gain_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end else if (busy_q) begin
				if ({1'b0, dly_q} >= step_val)
					dly_q <= dly_q - step_val[DLW-1:0];
				if (step_q == '0)
					busy_q <= 1'b0;
				else
					step_q <= step_q - 4'd1;
			end
		end
	end

	// write index and fill flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q   <= '0;
			wrap_q <= 1'b0;
		end else if (accept) begin
			if (wi_q == AW'(RING_DEPTH - 1)) begin
				wi_q   <= '0;
				wrap_q <= 1'b1;
			end else begin
				wi_q <= wi_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wi_s1     <= wi_q;
			fwd_s1    <= v_s1 && (rd_c == wi_s1);
			zero_s1   <= !(wrap_q || (rd_c < wi_q));
			sample_s1 <= sample_in;
		end
	end

	// ring RAM: read on accept, write on advance
	always_ff @(posedge clk) begin
		if (accept)
			rdata_s1 <= mem[rd_c];
		if (adv)
			mem[wi_s1] <= sat_c;
	end

	always_comb begin
		priority if (fwd_s1)
			dval_c = last_q;
		else if (zero_s1)
			dval_c = '0;
		else
			dval_c = rdata_s1;
		prod_c   = gain_q * dval_c;
		biased_c = prod_c + 32'sd16384;
		rnd_c    = 17'(biased_c >>> 15);
		sum_c    = 18'(sample_s1) + 18'(rnd_c);
		priority if (sum_c > 18'sd32767)
			sat_c = 16'sh7fff;
		else if (sum_c < -18'sd32768)
			sat_c = -16'sh8000;
		else
			sat_c = SW'(sum_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_q     <= sat_c;
			sample_out <= sat_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (res_ready) begin
			out_v_q <= 1'b0;
		end
	end

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !smp_ready)
		else $error("sample accepted during delay reduction");

	a_accept_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && v_s1) |-> adv)
		else $error("stage overwritten before advance");

	a_delay_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (32'(dly_q) < 32'(RING_DEPTH)))
		else $error("delay not reduced below ring depth");

	a_res_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_v_q)) |-> $past(v_s1))
		else $error("result without a stage item");

endmodule

// ===== verif/tb_feedback_comb_delay_top.sv =====
// ----------------------------------------------------------------------------
// tb_feedback_comb_delay_top
// Self-checking bench for the feedback comb delay. A scoreboard keeps its own
// ring, write pointer, delay and gain, predicts each saturated Q1.15 output
// for every accepted sample, and compares it in order with the results. The
// bench runs directed extremes, a streaming pass at delay RING_D (reduced to
// zero), random phases with sender gaps, receiver stalls and a long hold-off.
// ----------------------------------------------------------------------------
module tb_feedback_comb_delay_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_D      = fcd_pkg::RING_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 200;
	localparam int WRAP_ITEMS  = 200;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 90;
	localparam int MAX_REPORTS = 100;

	class comb_checker;
		logic signed [fcd_pkg::SMP_W-1:0] ring [RING_D];
		int                               wr_pos;
		logic [fcd_pkg::DLY_W-1:0]        delay_len;
		logic signed [fcd_pkg::SMP_W-1:0] gain;
		logic signed [fcd_pkg::SMP_W-1:0] expected_out [$];
		int                               errors;

		function new();
			foreach (ring[i]) ring[i] = '0;
			wr_pos = 0;
			delay_len = fcd_pkg::DLY_W'(fcd_pkg::DLY_RST);
			gain = '0;
			errors = 0;
		endfunction

		function void set_reg(fcd_pkg::reg_idx_t idx, logic [fcd_pkg::SMP_W-1:0] val);
			case (idx)
			fcd_pkg::REG_DELAY_LENGTH: delay_len = val[fcd_pkg::DLY_W-1:0];
			fcd_pkg::REG_FEEDBACK_GAIN: gain = val;
			endcase
		endfunction

		function logic signed [fcd_pkg::SMP_W-1:0] comb_output(
			logic signed [fcd_pkg::SMP_W-1:0] x);
			int     rd_pos;
			int     xin;
			int     g;
			int     dly;
			longint prod;
			longint acc;
			rd_pos = (wr_pos + RING_D - int'(delay_len) % RING_D) % RING_D;
			xin = x;
			g = gain;
			dly = ring[rd_pos];
			prod = longint'(g) * longint'(dly);
			// round Q2.30 to Q1.15, halves toward +inf
			acc = longint'(xin) + ((prod + 64'sd16384) >>> 15);
			if (acc > 32767)
				acc = 32767;
			else if (acc < -32768)
				acc = -32768;
			ring[wr_pos] = acc[fcd_pkg::SMP_W-1:0];
			wr_pos = (wr_pos + 1) % RING_D;
			return acc[fcd_pkg::SMP_W-1:0];
		endfunction

		function void note_sample(logic signed [fcd_pkg::SMP_W-1:0] x);
			expected_out.push_back(comb_output(x));
		endfunction

		task report_mismatch(string msg);
			if (errors < MAX_REPORTS)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic signed [fcd_pkg::SMP_W-1:0] got);
			logic signed [fcd_pkg::SMP_W-1:0] want;
			if (expected_out.size() == 0) begin
				report_mismatch($sformatf("sample_out %0d with nothing pending", got));
			end else begin
				want = expected_out.pop_front();
				if (got !== want)
					report_mismatch($sformatf("sample_out %0d, expected %0d", got, want));
			end
		endtask
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [0:0]                       cfg_index;
	logic [fcd_pkg::SMP_W-1:0]        cfg_data;
	logic                             smp_valid;
	logic                             smp_ready;
	logic signed [fcd_pkg::SMP_W-1:0] sample_in;
	logic                             res_valid;
	logic                             res_ready;
	logic signed [fcd_pkg::SMP_W-1:0] sample_out;

	comb_checker tracker;
	int          send_idle_pct;
	int          stall_pct;
	bit          hold_req;
	int          cycle_cnt = 0;

	logic signed [fcd_pkg::SMP_W-1:0] dir_vals [22] = '{
		16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1,
		16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0,
		-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
		16'sd1, -16'sd1, 16'sd3, -16'sd3, 16'sd0,
		16'sd100, -16'sd100
	};

	feedback_comb_delay_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.smp_valid  (smp_valid),
		.smp_ready  (smp_ready),
		.sample_in  (sample_in),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.sample_out (sample_out)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		bit hold_done;
		hold_done = 1'b0;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				res_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				res_ready = ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && res_valid && res_ready)
			tracker.check_result(sample_out);

	function automatic logic signed [fcd_pkg::SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
		0: return 16'sh7FFF;
		1: return 16'sh8000;
		2: return fcd_pkg::SMP_W'($urandom_range(0, 16) - 8);
		default: return fcd_pkg::SMP_W'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic signed [fcd_pkg::SMP_W-1:0] x);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			smp_valid = 1'b0;
			@(negedge clk);
		end
		smp_valid = 1'b1;
		sample_in = x;
		do @(posedge clk); while (!smp_ready);
		tracker.note_sample(x);
		@(negedge clk);
	endtask

	task automatic drain();
		smp_valid = 1'b0;
		while (tracker.expected_out.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input fcd_pkg::reg_idx_t idx,
		input logic [fcd_pkg::SMP_W-1:0] val);
		drain();
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		tracker.set_reg(idx, val);
	endtask

	initial begin
		logic [fcd_pkg::SMP_W-1:0] dly;
		logic [fcd_pkg::SMP_W-1:0] g;
		tracker = new();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		smp_valid = 1'b0;
		sample_in = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset settings, full-scale feedback, rounding halves, zero delay
		foreach (dir_vals[i]) begin
			case (i)
			5: begin
				write_reg(fcd_pkg::REG_DELAY_LENGTH, 16'd1);
				write_reg(fcd_pkg::REG_FEEDBACK_GAIN, 16'h8000);
			end
			11: begin
				write_reg(fcd_pkg::REG_DELAY_LENGTH, 16'd2);
				write_reg(fcd_pkg::REG_FEEDBACK_GAIN, 16'h7FFF);
			end
			15: begin
				write_reg(fcd_pkg::REG_DELAY_LENGTH, 16'd1);
				write_reg(fcd_pkg::REG_FEEDBACK_GAIN, 16'h4000);
			end
			20: begin
				write_reg(fcd_pkg::REG_DELAY_LENGTH, 16'd0);
				write_reg(fcd_pkg::REG_FEEDBACK_GAIN, 16'h7FFF);
			end
			default: ;
			endcase
			send_sample(dir_vals[i]);
		end

		// delay RING_D, reduced to zero, streaming
		write_reg(fcd_pkg::REG_DELAY_LENGTH, 16'(RING_D));
		write_reg(fcd_pkg::REG_FEEDBACK_GAIN, fcd_pkg::SMP_W'($urandom));
		for (int n = 0; n < WRAP_ITEMS; n++)
			send_sample(pick_sample());

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: dly = 16'd1;
			1: dly = 16'(RING_D);
			2: dly = 16'd0;
			3: dly = 16'hF001;
			4: dly = 16'(RING_D - 1);
			5: dly = 16'h1FFF;
			6: dly = 16'($urandom_range(2, 64));
			default: dly = 16'($urandom_range(1, RING_D));
			endcase
			case (p % 4)
			0: g = 16'h8000;
			1: g = 16'h7FFF;
			default: g = fcd_pkg::SMP_W'($urandom);
			endcase
			write_reg(fcd_pkg::REG_DELAY_LENGTH, dly);
			write_reg(fcd_pkg::REG_FEEDBACK_GAIN, g);
			case (p % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 62; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 62; end
			default: begin send_idle_pct = 25; stall_pct = 25; end
			endcase
			// hold the receiver off while the sender keeps pushing
			if (p == 4)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(pick_sample());
		end

		drain();
		repeat (10) @(posedge clk);
		if (tracker.expected_out.size() != 0)
			tracker.report_mismatch($sformatf("%0d results never arrived",
				tracker.expected_out.size()));
		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
